FILE: rtl/btwg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btwg_pkg;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned AMP_W     = 15;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned ANG_W     = 10;
  localparam int unsigned SINE_STEPS = 1 << ANG_W;
  localparam int unsigned QUARTER   = SINE_STEPS / 4;
  localparam int unsigned ROM_DEPTH = QUARTER + 1;
  localparam int unsigned IDX_W     = $clog2(ROM_DEPTH);
  localparam int unsigned DIV_STEPS = COUNT_W + ANG_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int unsigned CFG_IDX_W = 3;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  localparam logic [1:0] WAVE_SQUARE = 2'd1;
  localparam logic [1:0] WAVE_SINE   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_KIND   = 3'd0,
    CFG_PERIOD      = 3'd1,
    CFG_AMPLITUDE   = 3'd2,
    CFG_OFFSET      = 3'd3,
    CFG_CYCLE_COUNT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [FIELD_W-1:0] phase;
    logic [ANG_W-1:0]   ang;
  } div_res_t;

  typedef logic [FIELD_W-1:0] rom_t [ROM_DEPTH];

  // quarter-wave Q15 sine from an integer Taylor series in Q30
  function automatic rom_t sine_table();
    rom_t            tab;
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned r;
    longint unsigned s;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      theta = (HALF_PI_Q30 * longint'(k)) >> (ANG_W - 2);
      t2    = (theta * theta) >> 30;
      r     = ONE_Q30;
      r     = ONE_Q30 - (((r * t2) >> 30) / 64'd210);
      r     = ONE_Q30 - (((r * t2) >> 30) / 64'd156);
      r     = ONE_Q30 - (((r * t2) >> 30) / 64'd110);
      r     = ONE_Q30 - (((r * t2) >> 30) / 64'd72);
      r     = ONE_Q30 - (((r * t2) >> 30) / 64'd42);
      r     = ONE_Q30 - (((r * t2) >> 30) / 64'd20);
      r     = ONE_Q30 - (((r * t2) >> 30) / 64'd6);
      s = (theta * r) >> 30;
      s = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
        s = 64'd32767;
      end
      tab[k] = s[FIELD_W-1:0];
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/btwg_div.sv
`timescale 1ns / 1ps
`default_nettype none

module btwg_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire btwg_pkg::div_req_t  req_i,
  output btwg_pkg::div_res_t       res_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [btwg_pkg::STEP_W-1:0]       step_q, step_d;
  logic [btwg_pkg::COUNT_W-1:0]      dvd_q, dvd_d;
  logic [btwg_pkg::FIELD_W-1:0]      rem_q, rem_d;
  logic [btwg_pkg::FIELD_W-1:0]      div_q, div_d;
  logic [btwg_pkg::ANG_W-1:0]        quo_q, quo_d;
  logic [btwg_pkg::FIELD_W-1:0]      phase_q, phase_d;
  logic [btwg_pkg::FIELD_W:0]        shifted;
  logic [btwg_pkg::FIELD_W:0]        diff;
  logic                              ge;

  // one restoring step: count bits first, then zeros for the angle bits
  assign shifted = {rem_q, dvd_q[btwg_pkg::COUNT_W-1]};
  assign ge      = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    div_d   = div_q;
    quo_d   = quo_q;
    phase_d = phase_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[btwg_pkg::COUNT_W-2:0], 1'b0};
      rem_d  = ge ? diff[btwg_pkg::FIELD_W-1:0] : shifted[btwg_pkg::FIELD_W-1:0];
      quo_d  = {quo_q[btwg_pkg::ANG_W-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == btwg_pkg::STEP_W'(btwg_pkg::COUNT_W - 1)) begin
        phase_d = rem_d;
      end
      if (step_q == btwg_pkg::STEP_W'(btwg_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
    quo_q   <= quo_d;
    phase_q <= phase_d;
  end

  assign res_o.done  = done_q;
  assign res_o.phase = phase_q;
  assign res_o.ang   = quo_q;

endmodule

`default_nettype wire

FILE: rtl/btwg_sine_rom.sv
`timescale 1ns / 1ps
`default_nettype none

module btwg_sine_rom (
  input  wire logic                          clk_i,
  input  wire logic [btwg_pkg::ANG_W-1:0]    ang_i,
  output logic      [btwg_pkg::FIELD_W-1:0]  entry_o,
  output logic                               neg_o
);

  localparam btwg_pkg::rom_t SINE_ROM = btwg_pkg::sine_table();
  localparam int unsigned AW = btwg_pkg::ANG_W + 1;

  logic [AW-1:0]                    ang_w;
  logic [AW-1:0]                    idx_w;
  logic [btwg_pkg::IDX_W-1:0]       idx;
  logic                             neg;
  logic [btwg_pkg::FIELD_W-1:0]     entry_q;
  logic                             neg_q;

  // fold the angle onto the first quadrant
  always_comb begin
    ang_w = {1'b0, ang_i};
    neg   = 1'b0;
    if (ang_w > AW'(3 * btwg_pkg::QUARTER)) begin
      idx_w = AW'(btwg_pkg::SINE_STEPS) - ang_w;
      neg   = 1'b1;
    end else if (ang_w > AW'(2 * btwg_pkg::QUARTER)) begin
      idx_w = ang_w - AW'(2 * btwg_pkg::QUARTER);
      neg   = 1'b1;
    end else if (ang_w > AW'(btwg_pkg::QUARTER)) begin
      idx_w = AW'(2 * btwg_pkg::QUARTER) - ang_w;
    end else begin
      idx_w = ang_w;
    end
    if (idx_w > AW'(btwg_pkg::QUARTER)) begin
      idx_w = AW'(btwg_pkg::QUARTER);
    end
    idx = idx_w[btwg_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    entry_q <= SINE_ROM[idx];
    neg_q   <= neg;
  end

  assign entry_o = entry_q;
  assign neg_o   = neg_q;

endmodule

`default_nettype wire

FILE: rtl/burst_test_waveform_generator_top.sv
// Flow: a running tick with a non-zero period passes the divider, then ST_LIM, ST_AMP and
// ST_SUM; a zero period skips the divider; a stop or idle tick goes straight to ST_SUM.
// A new tick is taken only in ST_IDLE, after the last one is written out; the divider is a
// 42-step restoring divider (32 count bits for the phase, 10 more for the table angle).
// Reset: asynchronous, active low; generator stopped, count cleared, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module burst_test_waveform_generator_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                start_req_i,
  input  wire logic                                stop_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [btwg_pkg::FIELD_W-1:0]      sample_o,
  output logic                                     active_o,
  output logic                                     finished_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [btwg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [btwg_pkg::FIELD_W-1:0]        cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_LIM  = 5'b00100,
    ST_AMP  = 5'b01000,
    ST_SUM  = 5'b10000
  } state_e;

  localparam int unsigned FW = btwg_pkg::FIELD_W;
  localparam int unsigned CW = btwg_pkg::COUNT_W;
  localparam int unsigned SW = FW + 2;

  state_e                         state_q, state_d;
  logic [1:0]                     wave_q;
  logic [FW-1:0]                  period_q;
  logic [btwg_pkg::AMP_W-1:0]     amp_q;
  logic signed [FW-1:0]           offset_q;
  logic [FW-1:0]                  cycles_q;

  logic                           running_q, running_d;
  logic [CW-1:0]                  count_q, count_d;
  logic                           calc_q, calc_d;
  logic                           zper_q, zper_d;
  logic [CW-1:0]                  prod_q, prod_d;
  logic [CW-1:0]                  lim_q, lim_d;
  logic                           ovalid_q, ovalid_d;
  logic signed [FW-1:0]           osample_q, osample_d;
  logic                           oactive_q, oactive_d;
  logic                           ofin_q, ofin_d;

  btwg_pkg::div_req_t             div_req;
  btwg_pkg::div_res_t             div_res;
  logic [btwg_pkg::ANG_W-1:0]     ang_sel;
  logic [FW-1:0]                  phase_sel;
  logic [FW-1:0]                  entry;
  logic                           neg;
  logic [FW-1:0]                  mul_a, mul_b;
  logic                           accept;
  logic                           calc_now;
  logic                           slot_free;
  logic [CW-2:0]                  rnd;
  logic [FW-1:0]                  mag;
  logic signed [SW-1:0]           off_x;
  logic signed [SW-1:0]           dev_x;
  logic signed [SW-1:0]           sum;
  logic                           dev_neg;
  logic signed [FW-1:0]           sat;

  btwg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  assign ang_sel   = zper_q ? '0 : div_res.ang;
  assign phase_sel = zper_q ? '0 : div_res.phase;

  btwg_sine_rom u_rom (
    .clk_i   (clk_i),
    .ang_i   (ang_sel),
    .entry_o (entry),
    .neg_o   (neg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q   <= '0;
      period_q <= FW'(100);
      amp_q    <= '0;
      offset_q <= '0;
      cycles_q <= FW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        btwg_pkg::CFG_WAVE_KIND:   wave_q   <= cfg_data_i[1:0];
        btwg_pkg::CFG_PERIOD:      period_q <= cfg_data_i;
        btwg_pkg::CFG_AMPLITUDE:   amp_q    <= cfg_data_i[btwg_pkg::AMP_W-1:0];
        btwg_pkg::CFG_OFFSET:      offset_q <= cfg_data_i;
        btwg_pkg::CFG_CYCLE_COUNT: cycles_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign calc_now   = !stop_i && (start_req_i || running_q);
  assign slot_free  = !ovalid_q || out_ready_i;

  // shared multiplier: burst length, then amplitude times table entry
  always_comb begin
    mul_a = cycles_q;
    mul_b = period_q;
    if (state_q == ST_AMP) begin
      mul_a = {1'b0, amp_q};
      mul_b = entry;
    end
  end

  assign rnd     = prod_q[CW-2:0] + (CW-1)'(16384);
  assign mag     = rnd[CW-2:15];
  assign off_x   = {{2{offset_q[FW-1]}}, offset_q};
  assign dev_x   = (wave_q == btwg_pkg::WAVE_SINE) ? $signed({2'b00, mag})
                                                   : $signed({3'b000, amp_q});
  assign dev_neg = (wave_q == btwg_pkg::WAVE_SINE) ? neg
                                                   : (phase_sel >= (period_q >> 1));
  assign sum     = dev_neg ? off_x - dev_x : off_x + dev_x;

  always_comb begin
    if (sum > SW'(32767)) begin
      sat = 16'sh7fff;
    end else if (sum < -SW'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[FW-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    running_d = running_q;
    count_d   = count_q;
    calc_d    = calc_q;
    zper_d    = zper_q;
    prod_d    = prod_q;
    lim_d     = lim_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    osample_d = osample_q;
    oactive_d = oactive_q;
    ofin_d    = ofin_q;
    div_req.start    = 1'b0;
    div_req.dividend = count_d;
    div_req.divisor  = period_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          calc_d = calc_now;
          zper_d = (period_q == '0);
          if (calc_now) begin
            running_d = 1'b1;
            count_d   = (start_req_i ? '0 : count_q) + 1'b1;
            if (period_q == '0) begin
              state_d = ST_LIM;
            end else begin
              div_req.start = 1'b1;
              state_d       = ST_DIV;
            end
          end else begin
            running_d = 1'b0;
            count_d   = '0;
            state_d   = ST_SUM;
          end
          div_req.dividend = count_d;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_LIM;
        end
      end
      ST_LIM: begin
        prod_d  = CW'(mul_a) * CW'(mul_b);
        state_d = ST_AMP;
      end
      ST_AMP: begin
        lim_d   = prod_q;
        prod_d  = CW'(mul_a) * CW'(mul_b);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (slot_free) begin
          ovalid_d  = 1'b1;
          osample_d = '0;
          ofin_d    = 1'b0;
          if (calc_q) begin
            if (count_q >= lim_q) begin
              running_d = 1'b0;
              count_d   = '0;
              ofin_d    = 1'b1;
            end else if (wave_q == btwg_pkg::WAVE_SQUARE || wave_q == btwg_pkg::WAVE_SINE) begin
              osample_d = sat;
            end
          end
          oactive_d = running_d;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      running_q <= 1'b0;
      count_q   <= '0;
      calc_q    <= 1'b0;
      zper_q    <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      count_q   <= count_d;
      calc_q    <= calc_d;
      zper_q    <= zper_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    lim_q     <= lim_d;
    osample_q <= osample_d;
    oactive_q <= oactive_d;
    ofin_q    <= ofin_d;
  end

  assign out_valid_o = ovalid_q;
  assign sample_o    = osample_q;
  assign active_o    = oactive_q;
  assign finished_o  = ofin_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> count_q == '0)
    else $error("tick count held while stopped");

  a_fin_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> !active_o && sample_o == '0)
    else $error("finished transaction not quiet");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == ST_DIV)
    else $error("divider finished outside its step");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |=> !(accept && $past(state_q) == ST_DIV && state_q == ST_DIV))
    else $error("transaction taken while dividing");

endmodule

`default_nettype wire

FILE: test/tb_burst_test_waveform_generator_top.sv
`timescale 1ns / 1ps

module tb_burst_test_waveform_generator_top;

  localparam int unsigned ANGLE_STEPS  = 1024;
  localparam int unsigned QTR          = ANGLE_STEPS / 4;
  localparam logic [1:0]  WAVE_OFF     = 2'd0;
  localparam logic [1:0]  WAVE_SPARE   = 2'd3;
  localparam int          LIMIT_CYCLES = 1000000;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               active;
    logic               finished;
  } tick_outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        start_req = 1'b0;
  logic        stop_req = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [15:0] sample;
  logic        active;
  logic        finished;
  logic        cfg_we = 1'b0;
  btwg_pkg::cfg_idx_e cfg_idx = btwg_pkg::CFG_WAVE_KIND;
  logic [15:0] cfg_data = '0;

  // generator model state and its copy of the registers
  logic [1:0]         cfg_kind = WAVE_OFF;
  logic [15:0]        cfg_period = 16'd100;
  logic [14:0]        cfg_amp = '0;
  logic signed [15:0] cfg_offset = '0;
  logic [15:0]        cfg_cycles = 16'd1;
  logic               gen_on = 1'b0;
  logic [31:0]        tick_no = '0;
  logic [15:0]        quarter_sine [QTR+1];

  tick_outcome_t pending_outcomes [$];
  int n_errors = 0;
  int n_sent = 0;
  int cycle_cnt = 0;
  int gap_max = 3;
  int burst_left = 0;
  int ready_mode = 1;
  int ready_run = 0;
  int hold_cycles = 0;

  burst_test_waveform_generator_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .start_req_i (start_req),
    .stop_i      (stop_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .sample_o    (sample),
    .active_o    (active),
    .finished_o  (finished),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void build_quarter_sine();
    longint unsigned ang_q30;
    longint unsigned sq;
    longint unsigned acc;
    longint unsigned s;
    for (int k = 0; k <= QTR; k++) begin
      ang_q30 = (64'd1686629713 * longint'(k)) / QTR;
      sq      = (ang_q30 * ang_q30) >> 30;
      acc     = 64'd1 << 30;
      for (int n = 15; n >= 3; n -= 2) begin
        acc = (64'd1 << 30) - (((acc * sq) >> 30) / longint'(n * (n - 1)));
      end
      s = (ang_q30 * acc) >> 30;
      s = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
        s = 64'd32767;
      end
      quarter_sine[k] = s[15:0];
    end
  endfunction

  function automatic tick_outcome_t next_outcome(logic st, logic sp);
    tick_outcome_t res;
    logic [31:0]   ph;
    logic [31:0]   ang;
    logic [31:0]   burst_len;
    int            e;
    logic          neg;
    int            mag;
    int            lvl;
    res = '0;
    lvl = 0;
    if (sp) begin
      gen_on  = 1'b0;
      tick_no = '0;
    end else begin
      if (st) begin
        gen_on  = 1'b1;
        tick_no = '0;
      end
      if (gen_on) begin
        tick_no = tick_no + 32'd1;
        ph = (cfg_period != 0) ? tick_no % 32'(cfg_period) : 32'd0;
        if (cfg_kind == btwg_pkg::WAVE_SQUARE) begin
          if (ph < 32'(cfg_period >> 1)) begin
            lvl = int'(cfg_offset) + int'(cfg_amp);
          end else begin
            lvl = int'(cfg_offset) - int'(cfg_amp);
          end
        end else if (cfg_kind == btwg_pkg::WAVE_SINE) begin
          ang = (cfg_period != 0) ? (ph * ANGLE_STEPS) / 32'(cfg_period) : 32'd0;
          if (ang > 3 * QTR) begin
            e = int'(quarter_sine[ANGLE_STEPS - ang]);
            neg = 1'b1;
          end else if (ang > 2 * QTR) begin
            e = int'(quarter_sine[ang - 2 * QTR]);
            neg = 1'b1;
          end else if (ang > QTR) begin
            e = int'(quarter_sine[2 * QTR - ang]);
            neg = 1'b0;
          end else begin
            e = int'(quarter_sine[ang]);
            neg = 1'b0;
          end
          mag = (int'(cfg_amp) * e + 16384) >> 15;
          lvl = neg ? int'(cfg_offset) - mag : int'(cfg_offset) + mag;
        end
        if (lvl > 32767) begin
          lvl = 32767;
        end else if (lvl < -32768) begin
          lvl = -32768;
        end
        burst_len = 32'(cfg_cycles) * 32'(cfg_period);
        if (tick_no >= burst_len) begin
          lvl          = 0;
          gen_on       = 1'b0;
          tick_no      = '0;
          res.finished = 1'b1;
        end
      end else begin
        tick_no = '0;
      end
    end
    res.sample = lvl[15:0];
    res.active = gen_on;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  always @(posedge clk) begin : check_p
    tick_outcome_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_outcomes.push_back(next_outcome(start_req, stop_req));
      end
      if (out_valid && out_ready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("transaction out with nothing expected");
        end else begin
          want = pending_outcomes.pop_front();
          if (sample !== want.sample) begin
            report_mismatch($sformatf("sample %0d, want %0d", sample, want.sample));
          end
          if (active !== want.active) begin
            report_mismatch($sformatf("active %b, want %b", active, want.active));
          end
          if (finished !== want.finished) begin
            report_mismatch($sformatf("finished %b, want %b", finished, want.finished));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("tb_burst_test_waveform_generator_top failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles--;
    end else begin
      case (ready_mode)
        0: out_ready = 1'b1;
        1: out_ready = ($urandom_range(3, 0) != 0);
        default: begin
          if (ready_run == 0) begin
            out_ready = ~out_ready;
            ready_run = out_ready ? $urandom_range(12, 1) : $urandom_range(60, 1);
          end else begin
            ready_run--;
          end
        end
      endcase
    end
  end

  task automatic send_tick(input logic st, input logic sp);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = (gap_max > 0) ? $urandom_range(gap_max, 1) : 0;
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  = 1'b1;
    start_req = st;
    stop_req  = sp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_tick(1'b0, 1'b0);
  endtask

  // drop valid and let every outstanding transaction come back
  task automatic drain_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input btwg_pkg::cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    case (idx)
      btwg_pkg::CFG_WAVE_KIND:   cfg_kind = val[1:0];
      btwg_pkg::CFG_PERIOD:      cfg_period = val;
      btwg_pkg::CFG_AMPLITUDE:   cfg_amp = val[14:0];
      btwg_pkg::CFG_OFFSET:      cfg_offset = val;
      btwg_pkg::CFG_CYCLE_COUNT: cfg_cycles = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input logic [1:0] kind, input logic [15:0] period,
                           input logic [15:0] amp, input logic [15:0] offs,
                           input logic [15:0] cycles);
    drain_block();
    set_reg(btwg_pkg::CFG_WAVE_KIND, 16'(kind));
    set_reg(btwg_pkg::CFG_PERIOD, period);
    set_reg(btwg_pkg::CFG_AMPLITUDE, amp);
    set_reg(btwg_pkg::CFG_OFFSET, offs);
    set_reg(btwg_pkg::CFG_CYCLE_COUNT, cycles);
  endtask

  task automatic test_default_settings();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
  endtask

  task automatic test_square_saturation();
    configure(btwg_pkg::WAVE_SQUARE, 16'd4, 16'd32767, 16'h7FFF, 16'd1);
    send_tick(1'b1, 1'b0);
    run_ticks(3);
    configure(btwg_pkg::WAVE_SQUARE, 16'd4, 16'd32767, 16'h8000, 16'd1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
  endtask

  task automatic test_sine_quadrants();
    configure(btwg_pkg::WAVE_SINE, 16'd4, 16'd32767, 16'd0, 16'd1);
    send_tick(1'b1, 1'b0);
    run_ticks(3);
  endtask

  task automatic test_zero_period_and_count();
    configure(btwg_pkg::WAVE_SINE, 16'd0, 16'd1000, 16'd100, 16'd3);
    send_tick(1'b1, 1'b0);
    configure(btwg_pkg::WAVE_SQUARE, 16'd4, 16'd1000, 16'd100, 16'd0);
    send_tick(1'b1, 1'b0);
  endtask

  task automatic test_lowered_limit();
    configure(btwg_pkg::WAVE_SQUARE, 16'd4, 16'd123, -16'd77, 16'd3);
    send_tick(1'b1, 1'b0);
    run_ticks(4);
    drain_block();
    set_reg(btwg_pkg::CFG_CYCLE_COUNT, 16'd1);
    run_ticks(1);
  endtask

  // hold the output off while ticks keep coming, so the input stalls
  task automatic test_input_stall();
    gap_max    = 0;
    ready_mode = 0;
    configure(btwg_pkg::WAVE_SINE, 16'd12, 16'd20000, -16'd5, 16'd65535);
    send_tick(1'b1, 1'b0);
    hold_cycles = 500;
    run_ticks(30);
  endtask

  task automatic test_random_bursts(input int target);
    int            shape;
    int            n;
    int            k;
    longint        burst_len;
    logic [1:0]    kind;
    logic [15:0]   period;
    logic [15:0]   amp;
    logic [15:0]   offs;
    logic [15:0]   cycles;
    while (n_sent < target) begin
      k = $urandom_range(7, 0);
      kind = (k < 3) ? btwg_pkg::WAVE_SQUARE : (k < 6) ? btwg_pkg::WAVE_SINE :
             (k == 6) ? WAVE_OFF : WAVE_SPARE;
      k = $urandom_range(15, 0);
      period = (k == 0) ? 16'd0 : (k == 1) ? 16'hFFFF :
               (k == 2) ? 16'($urandom_range(65535, 1)) : 16'($urandom_range(24, 1));
      k = $urandom_range(7, 0);
      amp = (k == 0) ? 16'd0 : (k == 1) ? 16'd32767 : 16'($urandom_range(32767, 0));
      k = $urandom_range(7, 0);
      offs = (k == 0) ? 16'h8000 : (k == 1) ? 16'h7FFF : 16'($urandom_range(65535, 0));
      k = $urandom_range(15, 0);
      cycles = (k == 0) ? 16'd0 : (k == 1) ? 16'hFFFF :
               (k == 2) ? 16'($urandom_range(65535, 0)) : 16'($urandom_range(4, 1));
      configure(kind, period, amp, offs, cycles);
      k = $urandom_range(2, 0);
      gap_max    = (k == 0) ? 0 : (k == 1) ? 3 : 12;
      ready_mode = $urandom_range(2, 0);
      burst_len  = longint'(cfg_cycles) * longint'(cfg_period);
      shape = $urandom_range(9, 0);
      if (shape <= 6) begin
        send_tick(1'b1, 1'b0);
        n = (burst_len < 50) ? int'(burst_len) + $urandom_range(3, 0) : $urandom_range(40, 5);
        repeat (n) begin
          k = $urandom_range(39, 0);
          if (k == 0) begin
            send_tick(1'b0, 1'b1);
          end else if (k == 1) begin
            send_tick(1'b1, 1'b1);
          end else if (k == 2) begin
            send_tick(1'b1, 1'b0);
          end else begin
            send_tick(1'b0, 1'b0);
          end
        end
      end else if (shape == 7) begin
        repeat ($urandom_range(12, 4)) begin
          send_tick($urandom_range(3, 0) == 0, $urandom_range(3, 0) == 0);
        end
      end else if (shape == 8) begin
        send_tick(1'b1, 1'b0);
        run_ticks($urandom_range(6, 0));
        send_tick(1'b0, 1'b1);
        run_ticks($urandom_range(4, 1));
      end else begin
        send_tick(1'b1, 1'b0);
        run_ticks($urandom_range(8, 1));
        drain_block();
        set_reg(btwg_pkg::CFG_CYCLE_COUNT, 16'($urandom_range(2, 0)));
        run_ticks($urandom_range(6, 1));
      end
    end
  endtask

  initial begin
    build_quarter_sine();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_default_settings();
    test_square_saturation();
    test_sine_quadrants();
    test_zero_period_and_count();
    test_lowered_limit();
    test_input_stall();
    test_random_bursts(n_sent + 880);
    drain_block();
    repeat (60) @(posedge clk);
    if (n_errors == 0 && pending_outcomes.size() == 0) begin
      $display("tb_burst_test_waveform_generator_top passed");
    end else begin
      $display("tb_burst_test_waveform_generator_top failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/btwg_pkg.sv
rtl/btwg_div.sv
rtl/btwg_sine_rom.sv
rtl/burst_test_waveform_generator_top.sv
test/tb_burst_test_waveform_generator_top.sv
